[src/fbpa_pkg.sv]
// Package: shared constants and types for the block pool allocator.
`default_nettype none
package fbpa_pkg;
  localparam int FREE_DEPTH = 256;
  localparam int IDX_W = $clog2(FREE_DEPTH);
  localparam int CNT_W = IDX_W + 1;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_FAST  = 2'd2,
    OP_REFILL = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_NOMEM = 3'd1,
    ST_BAD   = 3'd2,
    ST_DUP   = 3'd3,
    ST_FULL  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_BASE  = 2'd0,
    CFG_ALIGN = 2'd1,
    CFG_SIZE  = 2'd2,
    CFG_COUNT = 2'd3
  } cfg_idx_t;
endpackage
`default_nettype wire

[src/fbpa_if.sv]
// Interfaces: request and result channels.
`default_nettype none
interface fbpa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] address_in;
  modport source (output valid, opcode, address_in, input ready);
  modport sink (input valid, opcode, address_in, output ready);
endinterface

interface fbpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] block_address;
  logic [8:0]  free_blocks;
  logic [8:0]  used_blocks;
  logic        no_free;
  modport source (output valid, status, block_address, free_blocks, used_blocks, no_free,
                  input ready);
  modport sink (input valid, status, block_address, free_blocks, used_blocks, no_free,
                output ready);
endinterface
`default_nettype wire

[src/fbpa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module fbpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/fbpa_geom.sv]
// Address check: offset alignment and bound, one offset bit per cycle.
`default_nettype none
module fbpa_geom (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] addr,
  input  wire logic [31:0] pool_base,
  input  wire logic [3:0]  align_shift,
  input  wire logic [16:0] req_size,
  input  wire logic [8:0]  eff_count,
  output logic             done,
  output logic             bad
);
  // Unit size is at most 2^17 so a restoring divide over 32 bits.
  logic        busy_r;
  logic [5:0]  step_r;
  logic [31:0] num_r;
  logic [32:0] rem_r;
  logic [31:0] quo_r;
  logic [17:0] size_r;
  logic        lowbad_r;
  logic [3:0]  sh;
  logic [17:0] unit, size_c;
  logic [32:0] rem_sh;

  always_comb begin
    sh = align_shift;
    if (sh < 4'd2) sh = 4'd2;
    if (sh > 4'd12) sh = 4'd12;
    unit = 18'd1 << sh;
    if (req_size == 17'd0) size_c = unit;
    else size_c = ({1'b0, req_size} + unit - 18'd1) & ~(unit - 18'd1);
    rem_sh = {rem_r[31:0], num_r[31]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      bad    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r   <= 1'b1;
        step_r   <= 6'd0;
        num_r    <= addr - pool_base;
        lowbad_r <= addr < pool_base;
        rem_r    <= '0;
        quo_r    <= '0;
        size_r   <= size_c;
      end else if (busy_r) begin
        num_r <= {num_r[30:0], 1'b0};
        if (rem_sh >= {15'd0, size_r}) begin
          rem_r <= rem_sh - {15'd0, size_r};
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[30:0], 1'b0};
        end
        step_r <= step_r + 6'd1;
        if (step_r == 6'd32) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
          bad    <= lowbad_r || (rem_r != '0) || (quo_r >= {23'd0, eff_count});
        end
      end
    end
  end
endmodule
`default_nettype wire

[src/fixed_block_pool_allocator_unit.sv]
// Top level: free-list allocator around one block-address RAM.
// Alloc and fast free pass through S_READ to S_OUT; a checked free first runs the
// bit-serial offset divide, then a read and a compare per entry, and ends early on a bad
// address; refill makes one write per block.
// One request at a time. Reset: synchronous active-low rst_n empties the list and loads
// the register defaults; the RAM is not cleared, as only pushed entries are read.
`default_nettype none
module fixed_block_pool_allocator_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  fbpa_req_if.sink        in_req,
  fbpa_rsp_if.source      out_rsp,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int IW = fbpa_pkg::IDX_W;
  localparam int CW = fbpa_pkg::CNT_W;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_GEOM, S_SCAN, S_FILL, S_OUT} state_t;

  state_t       state_r;
  logic [31:0]  base_r;
  logic [3:0]   align_r;
  logic [16:0]  bsize_r;
  logic [8:0]   bcount_r;
  logic [IW-1:0] head_r, tail_r, scan_r;
  logic [CW-1:0] total_r, cnt_r;
  logic [1:0]   op_r;
  logic [31:0]  addr_r, fill_r;
  logic         rd_pend_r;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  logic [8:0]    eff;
  logic [17:0]   unit_size;
  logic [3:0]    sh;
  logic          g_done, g_bad, g_start;
  logic [CW-1:0] tot_nxt;

  // Clamp the count to the list depth.
  assign eff = (bcount_r > 9'(fbpa_pkg::FREE_DEPTH)) ? 9'(fbpa_pkg::FREE_DEPTH) : bcount_r;

  always_comb begin
    sh = align_r;
    if (sh < 4'd2) sh = 4'd2;
    if (sh > 4'd12) sh = 4'd12;
    unit_size = 18'd1 << sh;
    if (bsize_r != 17'd0)
      unit_size = ({1'b0, bsize_r} + unit_size - 18'd1) & ~(unit_size - 18'd1);
  end

  fbpa_ram #(.WIDTH(32), .DEPTH(fbpa_pkg::FREE_DEPTH)) u_list (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  fbpa_geom u_geom (
    .clk(clk), .rst_n(rst_n), .start(g_start), .addr(addr_r), .pool_base(base_r),
    .align_shift(align_r), .req_size(bsize_r), .eff_count(eff),
    .done(g_done), .bad(g_bad)
  );

  assign in_req.ready = (state_r == S_IDLE) && !out_rsp.valid;
  assign g_start = (state_r == S_READ) && (op_r == fbpa_pkg::OP_FREE);
  assign raddr = (state_r == S_IDLE) ? head_r : scan_r;
  assign tot_nxt = total_r;

  // Push port: fast free, checked free, refill.
  always_comb begin
    we = 1'b0;
    waddr = tail_r;
    wdata = addr_r;
    if (state_r == S_FILL && cnt_r != '0) begin
      we = 1'b1;
      wdata = fill_r;
    end else if (state_r == S_READ && op_r == fbpa_pkg::OP_FAST &&
                 total_r < CW'(fbpa_pkg::FREE_DEPTH)) begin
      we = 1'b1;
    end else if (state_r == S_SCAN && !rd_pend_r && cnt_r == '0 &&
                 total_r < CW'(fbpa_pkg::FREE_DEPTH)) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      base_r <= '0;
      align_r <= 4'd2;
      bsize_r <= 17'd64;
      bcount_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      total_r <= '0;
      out_rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (fbpa_pkg::cfg_idx_t'(cfg_index))
          fbpa_pkg::CFG_BASE:  base_r <= cfg_data;
          fbpa_pkg::CFG_ALIGN: align_r <= cfg_data[3:0];
          fbpa_pkg::CFG_SIZE:  bsize_r <= cfg_data[16:0];
          fbpa_pkg::CFG_COUNT: bcount_r <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (out_rsp.valid && out_rsp.ready) out_rsp.valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_req.valid && in_req.ready) begin
            op_r <= in_req.opcode;
            addr_r <= in_req.address_in;
            out_rsp.status <= fbpa_pkg::ST_OK;
            out_rsp.block_address <= '0;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          // Head entry read is in rdata now.
          case (fbpa_pkg::opcode_t'(op_r))
            fbpa_pkg::OP_ALLOC: begin
              if (total_r == '0) begin
                out_rsp.status <= fbpa_pkg::ST_NOMEM;
              end else begin
                out_rsp.block_address <= rdata;
                head_r <= head_r + 1'b1;
                total_r <= total_r - 1'b1;
              end
              state_r <= S_OUT;
            end
            fbpa_pkg::OP_FAST: begin
              if (we) begin
                tail_r <= tail_r + 1'b1;
                total_r <= total_r + 1'b1;
              end else begin
                out_rsp.status <= fbpa_pkg::ST_FULL;
              end
              state_r <= S_OUT;
            end
            fbpa_pkg::OP_FREE: state_r <= S_GEOM;
            default: begin
              head_r <= '0;
              tail_r <= '0;
              total_r <= '0;
              cnt_r <= CW'(eff);
              fill_r <= base_r;
              state_r <= S_FILL;
            end
          endcase
        end
        S_GEOM: begin
          if (g_done) begin
            if (g_bad) begin
              out_rsp.status <= fbpa_pkg::ST_BAD;
              state_r <= S_OUT;
            end else begin
              scan_r <= head_r;
              cnt_r <= total_r;
              rd_pend_r <= 1'b0;
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Issue one read, compare next cycle.
          if (rd_pend_r) begin
            rd_pend_r <= 1'b0;
            if (rdata == addr_r) begin
              out_rsp.status <= fbpa_pkg::ST_DUP;
              state_r <= S_OUT;
            end else begin
              scan_r <= scan_r + 1'b1;
              cnt_r <= cnt_r - 1'b1;
            end
          end else if (cnt_r != '0) begin
            rd_pend_r <= 1'b1;
          end else begin
            if (we) begin
              tail_r <= tail_r + 1'b1;
              total_r <= total_r + 1'b1;
            end else begin
              out_rsp.status <= fbpa_pkg::ST_FULL;
            end
            state_r <= S_OUT;
          end
        end
        S_FILL: begin
          if (cnt_r != '0) begin
            tail_r <= tail_r + 1'b1;
            total_r <= total_r + 1'b1;
            fill_r <= fill_r + {14'd0, unit_size};
            cnt_r <= cnt_r - 1'b1;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          out_rsp.valid <= 1'b1;
          out_rsp.free_blocks <= 9'(tot_nxt);
          out_rsp.used_blocks <= (eff > 9'(tot_nxt)) ? eff - 9'(tot_nxt) : 9'd0;
          out_rsp.no_free <= (tot_nxt == '0);
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
